FILE: src/sbpe_pkg.sv
// Shared constants, types, microcode table and count helpers of the pair enumerator.
package sbpe_pkg;

    localparam int MAX_IRREPS     = 8;
    localparam int COUNT_BITS     = 8;
    localparam int IRREP_BITS     = 3;
    localparam int NUM_BITS       = IRREP_BITS + 1;
    localparam int IDX_BITS       = 11;
    localparam int CNT_BITS       = 22;
    localparam int CFG_WIDTH      = 64;
    localparam int CFG_INDEX_BITS = 2;
    localparam int STEP_BITS      = 4;
    localparam int COND_BITS      = 4;
    localparam int ACT_BITS       = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_COUNTS  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SECOND_COUNTS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IRREP_COUNT   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RESTRICTION   = 2'd3;

    localparam logic [1:0] RESTRICT_GE = 2'd1;
    localparam logic [1:0] RESTRICT_GT = 2'd2;

    typedef logic [STEP_BITS-1:0] step_t;
    typedef logic [COND_BITS-1:0] cond_t;
    typedef logic [ACT_BITS-1:0]  action_t;

    localparam cond_t COND_ALWAYS     = 4'd0;
    localparam cond_t COND_RESTART    = 4'd1;
    localparam cond_t COND_FINISHED   = 4'd2;
    localparam cond_t COND_BLOCK_OUT  = 4'd3;
    localparam cond_t COND_PIRREP_OUT = 4'd4;
    localparam cond_t COND_LAST_BLOCK = 4'd5;
    localparam cond_t COND_ROW_OUT    = 4'd6;
    localparam cond_t COND_COL_OUT    = 4'd7;
    localparam cond_t COND_REJECT     = 4'd8;

    localparam action_t ACT_NONE        = 4'd0;
    localparam action_t ACT_CLEAR       = 4'd1;
    localparam action_t ACT_SET_FIN     = 4'd2;
    localparam action_t ACT_BLOCK_WRAP  = 4'd3;
    localparam action_t ACT_INC_BLOCK   = 4'd4;
    localparam action_t ACT_NEXT_PIRREP = 4'd5;
    localparam action_t ACT_NEXT_ROW    = 4'd6;
    localparam action_t ACT_LOAD_PQ     = 4'd7;
    localparam action_t ACT_EMIT        = 4'd8;
    localparam action_t ACT_EMIT_DONE   = 4'd9;

    localparam step_t STEP_RESTART = 4'd0;
    localparam step_t STEP_FIN     = 4'd1;
    localparam step_t STEP_BLOCK   = 4'd2;
    localparam step_t STEP_PIRREP  = 4'd3;
    localparam step_t STEP_LAST    = 4'd4;
    localparam step_t STEP_ROW     = 4'd5;
    localparam step_t STEP_COL     = 4'd6;
    localparam step_t STEP_CHECK   = 4'd7;
    localparam step_t STEP_DONE    = 4'd8;

    typedef struct packed {
        cond_t   cond;
        action_t act_true;
        step_t   next_true;
        action_t act_false;
        step_t   next_false;
    } ucode_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] first_counts;
        logic [CFG_WIDTH-1:0] second_counts;
        logic [3:0]           irrep_count;
        logic [1:0]           restriction;
    } cfg_t;

    typedef struct packed {
        logic finished;
        logic block_out;
        logic pirrep_out;
        logic last_block;
        logic row_out;
        logic col_out;
        logic reject;
    } status_t;

    typedef struct packed {
        logic    fire;
        action_t act;
    } ctrl_t;

    function automatic ucode_t ucode_word(input step_t step);
        ucode_t w;
        unique case (step)
            STEP_RESTART: w = '{COND_RESTART,    ACT_CLEAR,       STEP_FIN,
                                ACT_NONE,        STEP_FIN};
            STEP_FIN:     w = '{COND_FINISHED,   ACT_NONE,        STEP_DONE,
                                ACT_NONE,        STEP_BLOCK};
            STEP_BLOCK:   w = '{COND_BLOCK_OUT,  ACT_SET_FIN,     STEP_DONE,
                                ACT_NONE,        STEP_PIRREP};
            STEP_PIRREP:  w = '{COND_PIRREP_OUT, ACT_BLOCK_WRAP,  STEP_LAST,
                                ACT_NONE,        STEP_ROW};
            STEP_LAST:    w = '{COND_LAST_BLOCK, ACT_SET_FIN,     STEP_DONE,
                                ACT_INC_BLOCK,   STEP_BLOCK};
            STEP_ROW:     w = '{COND_ROW_OUT,    ACT_NEXT_PIRREP, STEP_BLOCK,
                                ACT_NONE,        STEP_COL};
            STEP_COL:     w = '{COND_COL_OUT,    ACT_NEXT_ROW,    STEP_BLOCK,
                                ACT_LOAD_PQ,     STEP_CHECK};
            STEP_CHECK:   w = '{COND_REJECT,     ACT_NEXT_ROW,    STEP_BLOCK,
                                ACT_EMIT,        STEP_RESTART};
            default:      w = '{COND_ALWAYS,     ACT_EMIT_DONE,   STEP_RESTART,
                                ACT_EMIT_DONE,   STEP_RESTART};
        endcase
        return w;
    endfunction

    function automatic logic [NUM_BITS-1:0] irreps_in_use(input logic [3:0] cnt);
        logic [NUM_BITS-1:0] n;
        if (cnt == 4'd0) begin
            n = NUM_BITS'(1);
        end else if (cnt > 4'(MAX_IRREPS)) begin
            n = NUM_BITS'(MAX_IRREPS);
        end else begin
            n = NUM_BITS'(cnt);
        end
        return n;
    endfunction

    function automatic logic [COUNT_BITS-1:0] count_of(
        input logic [CFG_WIDTH-1:0] counts,
        input logic [NUM_BITS-1:0]  irrep,
        input logic [NUM_BITS-1:0]  n
    );
        logic [COUNT_BITS-1:0] c;
        c = '0;
        if (irrep < n && (int'(irrep) * COUNT_BITS) < CFG_WIDTH) begin
            c = counts[irrep[IRREP_BITS-1:0] * COUNT_BITS +: COUNT_BITS];
        end
        return c;
    endfunction

    function automatic logic [IDX_BITS-1:0] start_of(
        input logic [CFG_WIDTH-1:0] counts,
        input logic [NUM_BITS-1:0]  irrep,
        input logic [NUM_BITS-1:0]  n
    );
        logic [IDX_BITS-1:0] s;
        s = '0;
        for (int i = 0; i < MAX_IRREPS; i++) begin
            if (i < int'(irrep)) begin
                s = s + IDX_BITS'(count_of(counts, NUM_BITS'(i), n));
            end
        end
        return s;
    endfunction

endpackage

FILE: src/sbpe_datapath.sv
// Walk registers, candidate pair datapath and result payload registers.
module sbpe_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sbpe_pkg::cfg_t                     cfg,
    input  sbpe_pkg::ctrl_t                    ctrl,
    output sbpe_pkg::status_t                  status,
    output logic [sbpe_pkg::IDX_BITS-1:0]      first_index,
    output logic [sbpe_pkg::IDX_BITS-1:0]      second_index,
    output logic [sbpe_pkg::IRREP_BITS-1:0]    block_irrep,
    output logic [sbpe_pkg::CNT_BITS-1:0]      offset_in_block,
    output logic [sbpe_pkg::CNT_BITS-1:0]      pair_number,
    output logic                               done_res
);

    logic [sbpe_pkg::IRREP_BITS-1:0] block_reg, block_next;
    logic [sbpe_pkg::NUM_BITS-1:0]   pirrep_reg, pirrep_next;
    logic [sbpe_pkg::COUNT_BITS-1:0] row_reg, row_next;
    logic [sbpe_pkg::COUNT_BITS-1:0] col_reg, col_next;
    logic [sbpe_pkg::CNT_BITS-1:0]   running_reg, running_next;
    logic [sbpe_pkg::CNT_BITS-1:0]   block_start_reg, block_start_next;
    logic                            finished_reg, finished_next;
    logic [sbpe_pkg::IDX_BITS-1:0]   p_reg, p_next;
    logic [sbpe_pkg::IDX_BITS-1:0]   q_reg, q_next;

    logic [sbpe_pkg::IDX_BITS-1:0]   first_reg, first_next;
    logic [sbpe_pkg::IDX_BITS-1:0]   second_reg, second_next;
    logic [sbpe_pkg::IRREP_BITS-1:0] irrep_out_reg, irrep_out_next;
    logic [sbpe_pkg::CNT_BITS-1:0]   offset_reg, offset_next;
    logic [sbpe_pkg::CNT_BITS-1:0]   number_reg, number_next;
    logic                            done_reg, done_next;

    logic [sbpe_pkg::NUM_BITS-1:0]   n;
    logic [sbpe_pkg::IRREP_BITS-1:0] qs;
    logic [sbpe_pkg::COUNT_BITS-1:0] c0;
    logic [sbpe_pkg::COUNT_BITS-1:0] c1;

    always_comb begin
        n  = sbpe_pkg::irreps_in_use(cfg.irrep_count);
        qs = block_reg ^ pirrep_reg[sbpe_pkg::IRREP_BITS-1:0];
        c0 = sbpe_pkg::count_of(cfg.first_counts, pirrep_reg, n);
        c1 = sbpe_pkg::count_of(cfg.second_counts, sbpe_pkg::NUM_BITS'(qs), n);

        status.finished   = finished_reg;
        status.block_out  = sbpe_pkg::NUM_BITS'(block_reg) >= n;
        status.pirrep_out = pirrep_reg >= n;
        status.last_block = (sbpe_pkg::NUM_BITS'(block_reg) + 1'b1) >= n;
        status.row_out    = row_reg >= c0;
        status.col_out    = col_reg >= c1;
        unique case (cfg.restriction)
            sbpe_pkg::RESTRICT_GE: status.reject = p_reg < q_reg;
            sbpe_pkg::RESTRICT_GT: status.reject = p_reg <= q_reg;
            default:               status.reject = 1'b0;
        endcase
    end

    always_comb begin
        block_next       = block_reg;
        pirrep_next      = pirrep_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        running_next     = running_reg;
        block_start_next = block_start_reg;
        finished_next    = finished_reg;
        p_next           = p_reg;
        q_next           = q_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        irrep_out_next   = irrep_out_reg;
        offset_next      = offset_reg;
        number_next      = number_reg;
        done_next        = done_reg;
        if (ctrl.fire) begin
            unique case (ctrl.act)
                sbpe_pkg::ACT_CLEAR: begin
                    block_next       = '0;
                    pirrep_next      = '0;
                    row_next         = '0;
                    col_next         = '0;
                    running_next     = '0;
                    block_start_next = '0;
                    finished_next    = 1'b0;
                end
                sbpe_pkg::ACT_SET_FIN: begin
                    finished_next = 1'b1;
                end
                sbpe_pkg::ACT_BLOCK_WRAP: begin
                    pirrep_next      = '0;
                    row_next         = '0;
                    col_next         = '0;
                    block_start_next = running_reg;
                end
                sbpe_pkg::ACT_INC_BLOCK: begin
                    block_next = block_reg + 1'b1;
                end
                sbpe_pkg::ACT_NEXT_PIRREP: begin
                    pirrep_next = pirrep_reg + 1'b1;
                    row_next    = '0;
                    col_next    = '0;
                end
                sbpe_pkg::ACT_NEXT_ROW: begin
                    row_next = row_reg + 1'b1;
                    col_next = '0;
                end
                sbpe_pkg::ACT_LOAD_PQ: begin
                    p_next = sbpe_pkg::start_of(cfg.first_counts, pirrep_reg, n)
                             + sbpe_pkg::IDX_BITS'(row_reg);
                    q_next = sbpe_pkg::start_of(cfg.second_counts,
                                                sbpe_pkg::NUM_BITS'(qs), n)
                             + sbpe_pkg::IDX_BITS'(col_reg);
                end
                sbpe_pkg::ACT_EMIT: begin
                    first_next     = p_reg;
                    second_next    = q_reg;
                    irrep_out_next = block_reg;
                    offset_next    = running_reg - block_start_reg;
                    number_next    = running_reg;
                    done_next      = 1'b0;
                    col_next       = col_reg + 1'b1;
                    running_next   = running_reg + 1'b1;
                end
                sbpe_pkg::ACT_EMIT_DONE: begin
                    first_next     = '0;
                    second_next    = '0;
                    irrep_out_next = '0;
                    offset_next    = '0;
                    number_next    = '0;
                    done_next      = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_reg       <= '0;
            pirrep_reg      <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            running_reg     <= '0;
            block_start_reg <= '0;
            finished_reg    <= 1'b0;
        end else begin
            block_reg       <= block_next;
            pirrep_reg      <= pirrep_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            running_reg     <= running_next;
            block_start_reg <= block_start_next;
            finished_reg    <= finished_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg         <= p_next;
        q_reg         <= q_next;
        first_reg     <= first_next;
        second_reg    <= second_next;
        irrep_out_reg <= irrep_out_next;
        offset_reg    <= offset_next;
        number_reg    <= number_next;
        done_reg      <= done_next;
    end

    assign first_index     = first_reg;
    assign second_index    = second_reg;
    assign block_irrep     = irrep_out_reg;
    assign offset_in_block = offset_reg;
    assign pair_number     = number_reg;
    assign done_res        = done_reg;

    a_emit_ge: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.fire && ctrl.act == sbpe_pkg::ACT_EMIT
        && cfg.restriction == sbpe_pkg::RESTRICT_GE |-> p_reg >= q_reg)
        else $error("Emitted pair violates first >= second.");

    a_emit_gt: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.fire && ctrl.act == sbpe_pkg::ACT_EMIT
        && cfg.restriction == sbpe_pkg::RESTRICT_GT |-> p_reg > q_reg)
        else $error("Emitted pair violates first > second.");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.fire && ctrl.act == sbpe_pkg::ACT_EMIT
        |=> running_reg == $past(running_reg) + 1'b1)
        else $error("Running count did not advance by one on a transfer.");

endmodule

FILE: src/sbpe_sequencer.sv
// Microcode step counter, branch selection and input and result handshakes.
module sbpe_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_restart,
    output logic              m_valid,
    input  logic              m_ready,
    input  sbpe_pkg::status_t status,
    output sbpe_pkg::ctrl_t   ctrl
);

    logic            busy_reg, busy_next;
    sbpe_pkg::step_t pc_reg, pc_next;
    logic            restart_reg, restart_next;
    logic            m_valid_reg, m_valid_next;

    sbpe_pkg::ucode_t  word;
    logic              hit;
    sbpe_pkg::action_t act;
    sbpe_pkg::step_t   target;
    logic              last_step;
    logic              out_free;
    logic              fire;

    always_comb begin
        word = sbpe_pkg::ucode_word(pc_reg);
        unique case (word.cond)
            sbpe_pkg::COND_RESTART:    hit = restart_reg;
            sbpe_pkg::COND_FINISHED:   hit = status.finished;
            sbpe_pkg::COND_BLOCK_OUT:  hit = status.block_out;
            sbpe_pkg::COND_PIRREP_OUT: hit = status.pirrep_out;
            sbpe_pkg::COND_LAST_BLOCK: hit = status.last_block;
            sbpe_pkg::COND_ROW_OUT:    hit = status.row_out;
            sbpe_pkg::COND_COL_OUT:    hit = status.col_out;
            sbpe_pkg::COND_REJECT:     hit = status.reject;
            default:                   hit = 1'b1;
        endcase
        act       = hit ? word.act_true : word.act_false;
        target    = hit ? word.next_true : word.next_false;
        last_step = act == sbpe_pkg::ACT_EMIT || act == sbpe_pkg::ACT_EMIT_DONE;
        out_free  = !m_valid_reg || m_ready;
        fire      = busy_reg && (!last_step || out_free);
    end

    always_comb begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        restart_next = restart_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_valid && !busy_reg) begin
            busy_next    = 1'b1;
            pc_next      = sbpe_pkg::STEP_RESTART;
            restart_next = s_restart;
        end
        if (fire) begin
            if (last_step) begin
                busy_next    = 1'b0;
                m_valid_next = 1'b1;
            end else begin
                pc_next = target;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= sbpe_pkg::STEP_RESTART;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        restart_reg <= restart_next;
    end

    assign s_ready   = !busy_reg;
    assign m_valid   = m_valid_reg;
    assign ctrl.fire = fire;
    assign ctrl.act  = act;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !fire |=> busy_reg && pc_reg == $past(pc_reg))
        else $error("Sequencer moved while its result stage was blocked.");

    a_result_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(busy_reg))
        else $error("Result appeared without a request in progress.");

endmodule

FILE: src/symmetry_blocked_pair_enumerator.sv
// Top level of the symmetry-blocked pair enumerator: configuration registers and instances.
//
//  Channel   Direction  Handshake             Payload
//  s_        in         s_valid / s_ready     s_restart
//  m_        out        m_valid / m_ready     m_first_index, m_second_index, m_block_irrep,
//                                             m_offset_in_block, m_pair_number, m_done_res
//  cfg_      in         cfg_wr_en             cfg_index, cfg_wdata
//
// A request that finds its pair at once passes the restart, finished, block, irrep, row,
// column and pair-check microcode steps; each irrep, block or row passed over returns the
// walk to the block check. An exhausted walk answers done through the done step.
// Reset clears the walk and sets irrep_count to 1, all other configuration registers to zero.
// One request is served at a time; a new one is taken while the last result waits.
// A stalled result holds the sequencer at its final step until the result register frees.
module symmetry_blocked_pair_enumerator (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_restart,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [sbpe_pkg::IDX_BITS-1:0]          m_first_index,
    output logic [sbpe_pkg::IDX_BITS-1:0]          m_second_index,
    output logic [sbpe_pkg::IRREP_BITS-1:0]        m_block_irrep,
    output logic [sbpe_pkg::CNT_BITS-1:0]          m_offset_in_block,
    output logic [sbpe_pkg::CNT_BITS-1:0]          m_pair_number,
    output logic                                   m_done_res,
    input  logic                                   cfg_wr_en,
    input  logic [sbpe_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [sbpe_pkg::CFG_WIDTH-1:0]         cfg_wdata
);

    sbpe_pkg::cfg_t    cfg_reg, cfg_next;
    sbpe_pkg::status_t status;
    sbpe_pkg::ctrl_t   ctrl;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                sbpe_pkg::REG_FIRST_COUNTS:  cfg_next.first_counts  = cfg_wdata;
                sbpe_pkg::REG_SECOND_COUNTS: cfg_next.second_counts = cfg_wdata;
                sbpe_pkg::REG_IRREP_COUNT:   cfg_next.irrep_count   = cfg_wdata[3:0];
                sbpe_pkg::REG_RESTRICTION:   cfg_next.restriction   = cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_counts  <= '0;
            cfg_reg.second_counts <= '0;
            cfg_reg.irrep_count   <= 4'd1;
            cfg_reg.restriction   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sbpe_sequencer u_sequencer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    sbpe_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .ctrl            (ctrl),
        .status          (status),
        .first_index     (m_first_index),
        .second_index    (m_second_index),
        .block_irrep     (m_block_irrep),
        .offset_in_block (m_offset_in_block),
        .pair_number     (m_pair_number),
        .done_res        (m_done_res)
    );

endmodule
